// File: sv/epv_pkg.sv
// ----------------------------------------------------------------------------
// epv_pkg
// shared types and constants of the encoder position and velocity block
// ----------------------------------------------------------------------------
package epv_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_TOP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_LENGTH_LOG2 = 3'd4;

    // quarter-range wrap thresholds of the 16-bit counter
    localparam logic [15:0] WRAP_LOW  = 16'd16384;
    localparam logic [15:0] WRAP_HIGH = 16'd49152;

    // reciprocal of 1000 in 0.32 fixed point, and the modulus
    localparam logic signed [31:0] RECIP_1000 = 32'sd4294967;
    localparam logic signed [31:0] ANGLE_MOD  = 32'sd1000;

    // operand select of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_REF,
        MUL_ANGLE,
        MUL_FB,
        MUL_RECIP,
        MUL_MOD
    } mul_sel_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     load_in;
        logic     wrap_step;
        logic     pos_step;
        logic     ang_step;
        logic     fbm_step;
        logic     recip_step;
        logic     rem_step;
        logic     out_load;
        mul_sel_t mul_sel;
    } epv_cmd_t;

endpackage

// File: sv/epv_ctrl.sv
// ----------------------------------------------------------------------------
// epv_ctrl
// sequencer of one item through the shared multiplier and the output register
// ----------------------------------------------------------------------------
module epv_ctrl
    import epv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output epv_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WRAP  = 9'b000000010,
        S_POS   = 9'b000000100,
        S_ANG   = 9'b000001000,
        S_FBM   = 9'b000010000,
        S_RECIP = 9'b000100000,
        S_MODM  = 9'b001000000,
        S_REM   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{default: '0, mul_sel: MUL_NONE};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_WRAP;
                end
            end
            S_WRAP:
            begin
                cmd.wrap_step = 1'b1;
                state_next    = S_POS;
            end
            S_POS:
            begin
                cmd.pos_step = 1'b1;
                cmd.mul_sel  = MUL_REF;
                state_next   = S_ANG;
            end
            S_ANG:
            begin
                cmd.ang_step = 1'b1;
                cmd.mul_sel  = MUL_ANGLE;
                state_next   = S_FBM;
            end
            S_FBM:
            begin
                cmd.fbm_step = 1'b1;
                cmd.mul_sel  = MUL_FB;
                state_next   = S_RECIP;
            end
            S_RECIP:
            begin
                cmd.recip_step = 1'b1;
                cmd.mul_sel    = MUL_RECIP;
                state_next     = S_MODM;
            end
            S_MODM:
            begin
                cmd.mul_sel = MUL_MOD;
                state_next  = S_REM;
            end
            S_REM:
            begin
                cmd.rem_step = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/epv_dp.sv
// ----------------------------------------------------------------------------
// epv_dp
// datapath: wrap extension, shared multiplier, angle, speeds, median, average
// ----------------------------------------------------------------------------
module epv_dp
    import epv_pkg::*;
#(
    parameter int AVG_DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  epv_cmd_t               cmd,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [15:0]            encoder_count,
    input  logic [31:0]            reference_count,
    output logic signed [31:0]     feedback_position,
    output logic [10:0]            rotor_position,
    output logic signed [31:0]     feedback_speed,
    output logic signed [31:0]     reference_speed
);

    localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int KMAX  = $clog2(AVG_DEPTH + 1) - 1;

    // configuration
    logic [15:0]        encoder_top_reg;
    logic [23:0]        rpm_scale_reg;
    logic [30:0]        step_size_reg;
    logic signed [10:0] position_offset_reg;
    logic [2:0]         avg_log2_reg;

    // item and history state
    logic [15:0]        cnt_reg;
    logic [31:0]        refc_reg;
    logic [15:0]        last_cnt_reg;
    logic [31:0]        wrap_offset_reg, wrap_offset_next;
    logic [31:0]        prev_fb_pos_reg;
    logic [31:0]        prev_ref_pos_reg;
    logic [31:0]        ref_delta_reg;
    logic [31:0]        fb_delta_reg;
    logic [31:0]        pos_reg;
    logic [31:0]        rs_reg;
    logic [31:0]        t_reg;
    logic [31:0]        r_reg;
    logic [31:0]        med0_reg, med1_reg, med2_reg;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [63:0]        prod_reg;

    // moving average ring
    logic [31:0]        ring_mem [AVG_DEPTH];
    logic [AVG_DEPTH-1:0] ring_vld_reg;
    logic [31:0]        ring_rd_reg;
    logic               ring_rd_vld_reg;
    logic [31:0]        ring_old;
    logic [IDX_W-1:0]   ring_idx_reg, ring_idx_next;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   avg_len;
    logic [3:0]         avg_sh;
    logic [31:0]        sum_reg;

    // result forming
    logic [31:0]        fbs;
    logic [31:0]        r_adj;
    logic [31:0]        med;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoder_top_reg     <= 16'hFFFF;
            rpm_scale_reg       <= 24'd256;
            step_size_reg       <= 31'd65536;
            position_offset_reg <= '0;
            avg_log2_reg        <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENCODER_TOP:     encoder_top_reg     <= cfg_data[15:0];
                CFG_RPM_SCALE:       rpm_scale_reg       <= cfg_data[23:0];
                CFG_STEP_SIZE:       step_size_reg       <= cfg_data[30:0];
                CFG_POSITION_OFFSET: position_offset_reg <= $signed(cfg_data[10:0]);
                CFG_AVG_LENGTH_LOG2: avg_log2_reg        <= cfg_data[2:0];
                default:             ;
            endcase
        end
    end

    // wrap extension
    always_comb
    begin
        priority if (cnt_reg < WRAP_LOW && last_cnt_reg > WRAP_HIGH)
            wrap_offset_next = wrap_offset_reg + {16'd0, encoder_top_reg} + 32'd1;
        else if (cnt_reg > WRAP_HIGH && last_cnt_reg < WRAP_LOW)
            wrap_offset_next = wrap_offset_reg - {16'd0, encoder_top_reg} - 32'd1;
        else
            wrap_offset_next = wrap_offset_reg;
    end

    // multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_REF:
            begin
                mul_a = $signed(ref_delta_reg);
                mul_b = $signed({8'd0, rpm_scale_reg});
            end
            MUL_ANGLE:
            begin
                mul_a = $signed(pos_reg);
                mul_b = $signed({1'b0, step_size_reg});
            end
            MUL_FB:
            begin
                mul_a = $signed(fb_delta_reg);
                mul_b = $signed({8'd0, rpm_scale_reg});
            end
            MUL_RECIP:
            begin
                mul_a = $signed(t_reg);
                mul_b = RECIP_1000;
            end
            MUL_MOD:
            begin
                mul_a = $signed(prod_reg[63:32]);
                mul_b = ANGLE_MOD;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    // average length, clamped to what the ring holds
    assign avg_sh   = ({1'b0, avg_log2_reg} < 4'(KMAX)) ? {1'b0, avg_log2_reg} : 4'(KMAX);
    assign avg_len  = CNT_W'(1) << avg_sh;
    assign idx_inc  = {1'b0, ring_idx_reg} + CNT_W'(1);
    assign ring_idx_next = (idx_inc >= avg_len) ? '0 : idx_inc[IDX_W-1:0];
    assign ring_old = ring_rd_vld_reg ? ring_rd_reg : 32'd0;

    // ring memory
    always_ff @(posedge clk)
    begin
        if (cmd.fbm_step)
            ring_mem[ring_idx_reg] <= rs_reg;
        if (cmd.wrap_step)
            ring_rd_reg <= ring_mem[ring_idx_reg];
    end

    assign fbs = 32'($signed(prod_reg[31:0]) >>> 8);

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cnt_reg  <= encoder_count;
            refc_reg <= reference_count;
        end
        if (cmd.wrap_step)
        begin
            ref_delta_reg   <= refc_reg - prev_ref_pos_reg;
            ring_rd_vld_reg <= ring_vld_reg[ring_idx_reg];
        end
        if (cmd.pos_step)
            pos_reg <= wrap_offset_reg + {16'd0, cnt_reg};
        if (cmd.ang_step)
        begin
            rs_reg       <= 32'($signed(prod_reg[31:0]) >>> 8);
            fb_delta_reg <= pos_reg - prev_fb_pos_reg;
        end
        if (cmd.fbm_step)
            t_reg <= prod_reg[47:16];
        if (cmd.rem_step)
            r_reg <= t_reg - prod_reg[31:0] + 32'(position_offset_reg);
    end

    // history state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cnt_reg     <= '0;
            wrap_offset_reg  <= '0;
            prev_fb_pos_reg  <= '0;
            prev_ref_pos_reg <= '0;
            med0_reg         <= '0;
            med1_reg         <= '0;
            med2_reg         <= '0;
            ring_vld_reg     <= '0;
            ring_idx_reg     <= '0;
            sum_reg          <= '0;
        end
        else
        begin
            if (cmd.wrap_step)
            begin
                wrap_offset_reg  <= wrap_offset_next;
                last_cnt_reg     <= cnt_reg;
                prev_ref_pos_reg <= refc_reg;
            end
            if (cmd.ang_step)
            begin
                prev_fb_pos_reg <= pos_reg;
                sum_reg         <= sum_reg - ring_old;
            end
            if (cmd.fbm_step)
            begin
                sum_reg                    <= sum_reg + rs_reg;
                ring_vld_reg[ring_idx_reg] <= 1'b1;
                ring_idx_reg               <= ring_idx_next;
            end
            if (cmd.recip_step && med0_reg != fbs)
            begin
                med2_reg <= med1_reg;
                med1_reg <= med0_reg;
                med0_reg <= fbs;
            end
        end
    end

    // angle wrap into one period
    always_comb
    begin
        priority if (!($signed(r_reg) < 32'sd1000))
            r_adj = r_reg - 32'd1000;
        else if (r_reg[31])
            r_adj = r_reg + 32'd1000;
        else
            r_adj = r_reg;
    end

    // median of three, signed
    always_comb
    begin
        if ($signed(med2_reg) > $signed(med1_reg))
        begin
            priority if ($signed(med1_reg) > $signed(med0_reg))
                med = med1_reg;
            else if ($signed(med2_reg) > $signed(med0_reg))
                med = med0_reg;
            else
                med = med2_reg;
        end
        else
        begin
            priority if ($signed(med2_reg) > $signed(med0_reg))
                med = med2_reg;
            else if ($signed(med1_reg) > $signed(med0_reg))
                med = med0_reg;
            else
                med = med1_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            feedback_position <= $signed(pos_reg);
            rotor_position    <= r_adj[10:0];
            feedback_speed    <= $signed(med);
            reference_speed   <= $signed(sum_reg) >>> avg_sh;
        end
    end

endmodule

// File: sv/encoder_position_velocity.sv
// ----------------------------------------------------------------------------
// encoder_position_velocity
// wrap-extended encoder position, rotor angle, median-filtered feedback speed
// and moving-averaged reference speed, one result item per sample item
// ----------------------------------------------------------------------------
//
// channel   signals                                   direction
// --------  ----------------------------------------  ---------
// input     in_valid, in_stall, encoder_count,        in
//           reference_count
// output    out_valid, out_stall, feedback_position,  out
//           rotor_position, feedback_speed,
//           reference_speed
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// an item steps from acceptance through the sequencer states to its result in
// the output register, and no new item is taken before that result is loaded:
// five products pass one after another through a single 32x32 multiplier
// (reference speed, angle, feedback speed, reciprocal, modulo), plus wrap,
// remainder and output steps. the next item is accepted while a result still
// waits under out_stall; the final step then holds until the register frees.
// reset clears the sequencer, all history and the average ring valid bits, and
// loads the register defaults. cfg_ready is always high.
//
module encoder_position_velocity
    import epv_pkg::*;
#(
    parameter int AVG_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // sample items
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           encoder_count,
    input  logic [31:0]           reference_count,

    // result items
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    feedback_position,
    output logic [10:0]           rotor_position,
    output logic signed [31:0]    feedback_speed,
    output logic signed [31:0]    reference_speed,

    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    epv_cmd_t cmd;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: one item at a time through the datapath steps
    epv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: config registers, history, shared multiplier, ring, outputs
    epv_dp #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .encoder_count     (encoder_count),
        .reference_count   (reference_count),
        .feedback_position (feedback_position),
        .rotor_position    (rotor_position),
        .feedback_speed    (feedback_speed),
        .reference_speed   (reference_speed)
    );

endmodule

// File: verif/encoder_position_velocity_test.sv
// ----------------------------------------------------------------------------
// encoder_position_velocity_test
// self-checking bench for the encoder position and velocity block: a short
// directed walk over count thresholds and counter wraps, then random phases
// with fresh register settings, each item checked against a cycle-free
// predictor kept inside the bench
// ----------------------------------------------------------------------------
module encoder_position_velocity_test;
    import epv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH   = 16;
    localparam int RING_LOG2MAX = 4;          // largest k with 2**k <= RING_DEPTH
    localparam int ANGLE_SPAN   = 1000;
    localparam logic [63:0] RECIP_Q32 = 64'd4294967;
    localparam logic [15:0] QUARTER_LOW  = 16'd16384;
    localparam logic [15:0] QUARTER_HIGH = 16'd49152;
    localparam int PHASES       = 25;
    localparam int SETTLE_CYCLES = 20;

    // one result item, fields in port order
    typedef struct packed {
        logic signed [31:0] fb_position;
        logic [10:0]        rotor;
        logic signed [31:0] fb_speed;
        logic signed [31:0] ref_speed;
    } sample_result_t;

    // one directed row; want is used only where typed is set
    typedef struct packed {
        logic [15:0]    count;
        logic [31:0]    ref_count;
        logic           typed;
        sample_result_t want;
    } sample_row_t;

    // directed walk at reset settings (top 65535, scale 256, step 65536,
    // offset 0, average over 2): thresholds, wraps both ways, field extremes
    localparam int DIRECTED_ROWS = 22;
    localparam sample_row_t DIRECTED [DIRECTED_ROWS] = '{
        // first item after reset: everything zero
        '{16'd0,     32'd0,          1'b1, '{32'sd0,   11'd0,   32'sd0, 32'sd0}},
        // unit step: angle equals position, median still holds the zeros
        '{16'd100,   32'd0,          1'b1, '{32'sd100, 11'd100, 32'sd0, 32'sd0}},
        '{16'd100,   32'd512,        1'b0, '0},
        '{16'd16383, 32'hFFFF_FFFF,  1'b0, '0},
        '{16'd16384, 32'd0,          1'b0, '0},
        '{16'd49152, 32'h8000_0000,  1'b0, '0},
        '{16'd49153, 32'h7FFF_FFFF,  1'b0, '0},
        '{16'd65535, 32'd0,          1'b0, '0},
        // forward wrap, then backward, then forward again
        '{16'd0,     32'd1,          1'b0, '0},
        '{16'd65535, 32'd2,          1'b0, '0},
        '{16'd0,     32'd3,          1'b0, '0},
        '{16'd1000,  32'd4000,       1'b0, '0},
        '{16'd60000, 32'd8000,       1'b0, '0},
        '{16'd5000,  32'd12000,      1'b0, '0},
        '{16'd60000, 32'd16000,      1'b0, '0},
        '{16'd10000, 32'd20000,      1'b0, '0},
        // high count after a low one: backward wrap
        '{16'd49153, 32'd20000,      1'b0, '0},
        // low count after a high one but not below the quarter: no wrap
        '{16'd16384, 32'd20000,      1'b0, '0},
        '{16'd32768, 32'h5555_5555,  1'b0, '0},
        '{16'h5555,  32'hAAAA_AAAA,  1'b0, '0},
        '{16'hAAAA,  32'h0000_FFFF,  1'b0, '0},
        '{16'hFFFF,  32'hFFFF_0000,  1'b0, '0}
    };

    localparam logic [15:0] EDGE_COUNTS [8] = '{
        16'd0, 16'd16383, 16'd16384, 16'd16385,
        16'd49151, 16'd49152, 16'd49153, 16'd65535
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [15:0]           encoder_count;
    logic [31:0]           reference_count;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [31:0]    feedback_position;
    logic [10:0]           rotor_position;
    logic signed [31:0]    feedback_speed;
    logic signed [31:0]    reference_speed;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    encoder_position_velocity #(
        .AVG_DEPTH (RING_DEPTH)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .encoder_count     (encoder_count),
        .reference_count   (reference_count),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .feedback_position (feedback_position),
        .rotor_position    (rotor_position),
        .feedback_speed    (feedback_speed),
        .reference_speed   (reference_speed),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: register copies and the block's history
    // ------------------------------------------------------------------
    logic [15:0]        top_count;
    logic [23:0]        rpm_factor;
    logic [30:0]        angle_step;
    logic signed [10:0] angle_offset;
    logic [2:0]         ring_log2;

    logic [15:0]        last_count;
    logic [31:0]        wrap_base;
    logic [31:0]        last_fb_position;
    logic [31:0]        last_ref_count;
    logic signed [31:0] median_taps [3];
    logic [31:0]        speed_ring [RING_DEPTH];
    int unsigned        ring_pos;
    logic [31:0]        ring_sum;

    sample_result_t pending_results [$];
    int             error_count;
    int             results_taken;

    // idling controls, changed by the stimulus between phases
    int tx_max_gap;
    int rx_max_gap;
    int rx_hold_requests;         // bumped to ask the receiver for a long hold-off

    function automatic void reset_predictor();
        top_count        = 16'hFFFF;
        rpm_factor       = 24'd256;
        angle_step       = 31'd65536;
        angle_offset     = '0;
        ring_log2        = 3'd1;
        last_count       = '0;
        wrap_base        = '0;
        last_fb_position = '0;
        last_ref_count   = '0;
        ring_pos         = 0;
        ring_sum         = '0;
        for (int i = 0; i < 3; i++)
            median_taps[i] = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            speed_ring[i] = '0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_ENCODER_TOP:     top_count    = value[15:0];
            CFG_RPM_SCALE:       rpm_factor   = value[23:0];
            CFG_STEP_SIZE:       angle_step   = value[30:0];
            CFG_POSITION_OFFSET: angle_offset = value[10:0];
            CFG_AVG_LENGTH_LOG2: ring_log2    = value[2:0];
            default: ;
        endcase
    endfunction

    // counts per tick times the q8 factor, wrapped to 32 bits, arithmetic >> 8
    function automatic logic [31:0] scale_to_rpm(logic [31:0] delta);
        logic [31:0] prod;
        prod = delta * {8'd0, rpm_factor};
        return $signed(prod) >>> 8;
    endfunction

    function automatic sample_result_t predict_sample(logic [15:0] count,
                                                      logic [31:0] ref_count);
        sample_result_t     res;
        logic [31:0]        pos;
        logic [63:0]        wide;
        logic [31:0]        turns;
        logic [31:0]        quot;
        logic signed [31:0] angle;
        logic [31:0]        ref_rpm;
        logic signed [31:0] fb_rpm;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        int                 shift;
        int unsigned        ring_len;

        // extend the counter across wraps with the quarter-range test
        if (count < QUARTER_LOW && last_count > QUARTER_HIGH)
            wrap_base = wrap_base + {16'd0, top_count} + 32'd1;
        else if (count > QUARTER_HIGH && last_count < QUARTER_LOW)
            wrap_base = wrap_base - {16'd0, top_count} - 32'd1;
        last_count = count;
        pos = wrap_base + {16'd0, count};

        // angle: q16 scaling, then modulo 1000 by reciprocal multiply
        wide  = {{32{pos[31]}}, pos} * {33'd0, angle_step};
        turns = wide[47:16];
        wide  = {{32{turns[31]}}, turns} * RECIP_Q32;
        quot  = wide[63:32];
        angle = turns - quot * 32'd1000;
        angle = angle + angle_offset;
        if (angle >= ANGLE_SPAN)
            angle = angle - ANGLE_SPAN;
        else if (angle < 0)
            angle = angle + ANGLE_SPAN;

        // reference speed through the moving average ring
        ref_rpm = scale_to_rpm(ref_count - last_ref_count);
        last_ref_count = ref_count;
        shift    = (ring_log2 > RING_LOG2MAX) ? RING_LOG2MAX : int'(ring_log2);
        ring_len = 1 << shift;
        if (ring_pos >= RING_DEPTH)
            ring_pos = 0;
        ring_sum = ring_sum - speed_ring[ring_pos] + ref_rpm;
        speed_ring[ring_pos] = ref_rpm;
        ring_pos++;
        if (ring_pos >= ring_len)
            ring_pos = 0;

        // feedback speed enters the median window only when it changes
        fb_rpm = scale_to_rpm(pos - last_fb_position);
        last_fb_position = pos;
        if (median_taps[0] != fb_rpm)
        begin
            median_taps[2] = median_taps[1];
            median_taps[1] = median_taps[0];
            median_taps[0] = fb_rpm;
        end
        a = median_taps[0];
        b = median_taps[1];
        c = median_taps[2];

        res.fb_position = pos;
        res.rotor       = angle[10:0];
        res.fb_speed    = (a > b) ? ((b > c) ? b : ((a > c) ? c : a))
                                  : ((a > c) ? a : ((b > c) ? c : b));
        res.ref_speed   = $signed(ring_sum) >>> shift;
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // clock, reset and the run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        // worst correct run is roughly 1.5 ms; this leaves plenty of room
        #10_000_000;
        $display("encoder_position_velocity_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // result checking: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_taken++;
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("result item with nothing expected: pos %h",
                                       feedback_position));
            end
            else
            begin
                want = pending_results.pop_front();
                if (feedback_position !== want.fb_position)
                    report_error($sformatf("feedback_position got %h expected %h",
                                           feedback_position, want.fb_position));
                if (rotor_position !== want.rotor)
                    report_error($sformatf("rotor_position got %0d expected %0d",
                                           rotor_position, want.rotor));
                if (feedback_speed !== want.fb_speed)
                    report_error($sformatf("feedback_speed got %h expected %h",
                                           feedback_speed, want.fb_speed));
                if (reference_speed !== want.ref_speed)
                    report_error($sformatf("reference_speed got %h expected %h",
                                           reference_speed, want.ref_speed));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: a fresh stall draw for each result item, plus a long
    // hold-off on request so the block backs up into its input
    // ------------------------------------------------------------------
    initial
    begin
        int seen_taken;
        int seen_holds;
        int stall_left;
        int hold_left;
        seen_taken = 0;
        seen_holds = 0;
        stall_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (results_taken != seen_taken)
            begin
                seen_taken = results_taken;
                stall_left = $urandom_range(0, rx_max_gap);
            end
            if (rx_hold_requests != seen_holds)
            begin
                seen_holds = rx_hold_requests;
                hold_left  = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall = 1'b1;
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers; each is entered and left at a falling edge
    // ------------------------------------------------------------------

    // offer one sample item after a random gap, hold it until taken
    task automatic send_sample(input logic [15:0] count, input logic [31:0] ref_count,
                               input logic typed, input sample_result_t want);
        int gap;
        sample_result_t pred;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        = 1'b1;
        encoder_count   = count;
        reference_count = ref_count;
        do
            @(posedge clk);
        while (in_stall);
        // the predictor always advances; typed rows replace its answer
        pred = predict_sample(count, ref_count);
        pending_results.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one register write; the caller lowers cfg_valid after a batch
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, value);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int                    items;
        int                    mode;
        int                    span;
        int                    enc_walk;
        int                    enc_vel;
        int                    ref_vel;
        logic [31:0]           ref_walk;
        logic [15:0]           count;
        logic [31:0]           ref_count;
        logic [15:0]           new_top;
        logic [23:0]           new_scale;
        logic [30:0]           new_step;
        logic signed [10:0]    new_offset;
        logic [2:0]            new_log2;
        logic                  write_all;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        encoder_count    = '0;
        reference_count  = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_ENCODER_TOP;
        cfg_data         = '0;
        error_count      = 0;
        results_taken    = 0;
        rx_hold_requests = 0;
        tx_max_gap       = 15;
        rx_max_gap       = 15;
        enc_walk         = 0;
        ref_walk         = '0;
        reset_predictor();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed walk at the reset register values
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_sample(DIRECTED[i].count, DIRECTED[i].ref_count,
                        DIRECTED[i].typed, DIRECTED[i].want);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // new settings while idle; the first four phases pin the extremes,
            // including offsets past +-1000 and average lengths beyond the ring
            write_all = 1'b1;
            case (phase)
                0:
                begin
                    new_top = 16'd0;      new_scale = 24'd0;        new_step = 31'd0;
                    new_offset = -11'sd1024;                        new_log2 = 3'd0;
                end
                1:
                begin
                    new_top = 16'hFFFF;   new_scale = 24'hFF_FFFF;  new_step = 31'h7FFF_FFFF;
                    new_offset = 11'sd1023;                         new_log2 = 3'd7;
                end
                2:
                begin
                    new_top = 16'd1;      new_scale = 24'd1;        new_step = 31'd1;
                    new_offset = -11'sd1000;                        new_log2 = 3'd4;
                end
                3:
                begin
                    new_top = 16'd32767;  new_scale = 24'd256;      new_step = 31'd65536;
                    new_offset = 11'sd1000;                         new_log2 = 3'd5;
                end
                default:
                begin
                    write_all = 1'b0;
                    case ($urandom_range(0, 2))
                        0:       new_top = 16'hFFFF;
                        1:       new_top = 16'($urandom_range(0, 65535));
                        default: new_top = 16'($urandom_range(100, 5000));
                    endcase
                    case ($urandom_range(0, 2))
                        0:       new_scale = 24'd256;
                        1:       new_scale = 24'($urandom_range(0, 24'hFF_FFFF));
                        default: new_scale = 24'($urandom_range(0, 4096));
                    endcase
                    case ($urandom_range(0, 2))
                        0:       new_step = 31'd65536;
                        1:       new_step = 31'($urandom);
                        default: new_step = 31'($urandom_range(0, 1 << 20));
                    endcase
                    if ($urandom_range(0, 9) == 0)
                        new_offset = 11'($urandom);
                    else
                        new_offset = 11'(int'($urandom_range(0, 2000)) - 1000);
                    new_log2 = 3'($urandom_range(0, 7));
                end
            endcase
            // random phases change only some registers, so the average length
            // sometimes changes under a ring that still holds old samples
            if (write_all || $urandom_range(0, 1))
                write_register(CFG_ENCODER_TOP, {15'd0, new_top});
            if (write_all || $urandom_range(0, 1))
                write_register(CFG_RPM_SCALE, {7'd0, new_scale});
            if (write_all || $urandom_range(0, 1))
                write_register(CFG_STEP_SIZE, new_step);
            if (write_all || $urandom_range(0, 1))
                write_register(CFG_POSITION_OFFSET, {20'd0, new_offset});
            if (write_all || $urandom_range(0, 1))
                write_register(CFG_AVG_LENGTH_LOG2, {28'd0, new_log2});
            cfg_valid = 1'b0;

            // idling per phase, with whole phases of back-to-back traffic
            tx_max_gap = (phase % 4 == 3) ? 0 : 15;
            rx_max_gap = (phase % 5 == 2) ? 0 : 15;

            // back-pressure: the receiver holds off while items keep coming
            if (phase == 5 || phase == 17)
            begin
                tx_max_gap = 0;
                rx_hold_requests++;
            end

            // motion profile of this phase: mostly smooth counter motion,
            // sometimes standing still so the median sees repeated speeds
            enc_vel = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 8000)) - 4000;
            if ($urandom_range(0, 3) == 0)
                ref_vel = $urandom;
            else
                ref_vel = int'($urandom_range(0, 200000)) - 100000;
            span  = int'(top_count) + 1;
            items = $urandom_range(40, 80);

            for (int n = 0; n < items; n++)
            begin
                // sender pause partway through: wait for everything to return
                if (phase == 8 && n == items / 2)
                    drain_results();
                mode = $urandom_range(0, 9);
                if (mode == 0)
                begin
                    count     = 16'($urandom);
                    ref_count = $urandom;
                end
                else if (mode == 1)
                begin
                    count     = EDGE_COUNTS[$urandom_range(0, 7)];
                    ref_count = $urandom;
                end
                else
                begin
                    enc_walk  = ((enc_walk + enc_vel + int'($urandom_range(0, 20)) - 10)
                                 % span + span) % span;
                    ref_walk  = ref_walk + ref_vel + $urandom_range(0, 64);
                    count     = enc_walk[15:0];
                    ref_count = ref_walk;
                end
                send_sample(count, ref_count, 1'b0, '0);
            end
            drain_results();
        end

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("encoder_position_velocity_test: PASS");
        else
            $display("encoder_position_velocity_test: FAIL");
        $finish;
    end

endmodule
